### rtl/ecc_pkg.sv
// Shared types, constants and register indexes for the elevator car controller.
`timescale 1ns / 1ps

package ecc_pkg;

    localparam int NUM_FLOORS = 8;
    localparam int FLOOR_W    = 3;
    localparam int QCNT_W     = 4;
    localparam int POS_W      = 17;
    localparam int DOOR_W     = 10;
    localparam int MS_W       = 10;
    localparam int STEP_W     = 14;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAR_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_FULL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_CAP     = 3'd5;

    // Configuration reset values
    localparam logic [12:0]       RST_FLOOR_HEIGHT = 13'd3000;
    localparam logic [3:0]        RST_CAR_SPEED    = 4'd3;
    localparam logic [3:0]        RST_DOOR_SPEED   = 4'd2;
    localparam logic [DOOR_W-1:0] RST_DOOR_FULL    = 10'd500;
    localparam logic [15:0]       RST_DOOR_HOLD    = 16'd5000;
    localparam logic [MS_W-1:0]   RST_TICK_CAP     = 10'd50;

    // Command codes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_ADD   = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_OPEN  = 3'd3;
    localparam logic [2:0] MODE_CLOSE = 3'd4;

    // Reported phase codes
    localparam logic [1:0] PCODE_IDLE    = 2'd0;
    localparam logic [1:0] PCODE_MOVING  = 2'd1;
    localparam logic [1:0] PCODE_OPEN    = 2'd2;
    localparam logic [1:0] PCODE_CLOSING = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_MOVING  = 4'b0010,
        PH_OPEN    = 4'b0100,
        PH_CLOSING = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0]            phase;
        logic [FLOOR_W-1:0]    current_floor;
        logic [FLOOR_W-1:0]    destination_floor;
        logic [POS_W-1:0]      car_position_mm;
        logic [DOOR_W-1:0]     door_offset;
        logic                  doors_open;
        logic [NUM_FLOORS-1:0] buttons_lit;
        logic                  stop_active;
    } rsp_item_t;

endpackage

### rtl/ecc_req_if.sv
// Command and tick channel of the elevator car controller.
`timescale 1ns / 1ps

interface ecc_req_if;
    import ecc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [2:0]            mode;
    logic [FLOOR_W-1:0]    floor;
    logic [MS_W-1:0]       elapsed_ms;
    logic [TIME_W-1:0]     time_now_ms;

    modport source (output valid, output mode, output floor, output elapsed_ms,
                    output time_now_ms, input ready);
    modport sink (input valid, input mode, input floor, input elapsed_ms,
                  input time_now_ms, output ready);
endinterface

### rtl/ecc_rsp_if.sv
// Status channel of the elevator car controller.
`timescale 1ns / 1ps

interface ecc_rsp_if;
    import ecc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            phase;
    logic [FLOOR_W-1:0]    current_floor;
    logic [FLOOR_W-1:0]    destination_floor;
    logic [POS_W-1:0]      car_position_mm;
    logic [DOOR_W-1:0]     door_offset;
    logic                  doors_open;
    logic [NUM_FLOORS-1:0] buttons_lit;
    logic                  stop_active;

    modport source (output valid, output phase, output current_floor,
                    output destination_floor, output car_position_mm, output door_offset,
                    output doors_open, output buttons_lit, output stop_active, input ready);
    modport sink (input valid, input phase, input current_floor, input destination_floor,
                  input car_position_mm, input door_offset, input doors_open,
                  input buttons_lit, input stop_active, output ready);
endinterface

### rtl/elevator_car_controller.sv
// Elevator car controller: command/tick handling, request queue and status output.
`timescale 1ns / 1ps
//
// Usage:
//   req carries one item per transfer: a tick (elapsed and absolute ms) or a
//   command (add floor, stop, open doors, close doors). rsp returns exactly one
//   status item per accepted req item, in order, with the full visible state
//   after that item.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_data, one
//   register per cycle; only while no item is in flight, which the user must ensure.
//   Status goes into the output register, or the skid register while it is held.
//   Throughput: one item per cycle unless stalled; the state update is one pass of
//   logic from the state registers into the state and status registers.
//   A two-entry status buffer (output register plus skid register) lets req
//   keep transferring while one status waits; req.ready drops only while the
//   skid register is occupied, so a stalled receiver halts input after two
//   pending results.
//   Reset: car idle at floor zero, doors shut, queue empty, buttons dark,
//   configuration at its default values, status buffer empty.
//
module elevator_car_controller
    import ecc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ecc_req_if.sink               req,
    ecc_rsp_if.source             rsp
);

    // Configuration
    logic [12:0]       floor_height_reg;
    logic [3:0]        car_speed_reg;
    logic [3:0]        door_speed_reg;
    logic [DOOR_W-1:0] door_full_reg;
    logic [15:0]       door_hold_reg;
    logic [MS_W-1:0]   tick_cap_reg;

    // Car state
    phase_t                phase_reg, phase_next;
    logic [POS_W-1:0]      car_pos_reg, car_pos_next;
    logic [FLOOR_W-1:0]    arrived_reg, arrived_next;
    logic [FLOOR_W-1:0]    heading_reg, heading_next;
    logic [DOOR_W-1:0]     door_travel_reg, door_travel_next;
    logic                  door_flag_reg, door_flag_next;
    logic [TIME_W-1:0]     open_start_reg, open_start_next;
    logic                  hold_ext_reg, hold_ext_next;
    logic                  frozen_reg, frozen_next;
    logic [FLOOR_W-1:0]    fifo_head_reg, fifo_head_next;
    logic [QCNT_W-1:0]     fifo_count_reg, fifo_count_next;
    logic [NUM_FLOORS-1:0] queued_reg, queued_next;
    logic [NUM_FLOORS-1:0] lit_reg, lit_next;

    // Request queue storage, no reset: entries are read only after a write
    logic [FLOOR_W-1:0]    pending_mem [NUM_FLOORS];
    logic                  pend_we;
    logic [FLOOR_W-1:0]    pend_waddr;

    // Status buffer
    logic      out_valid_reg, out_valid_next;
    rsp_item_t out_data_reg, out_data_next;
    logic      skid_valid_reg, skid_valid_next;
    rsp_item_t skid_data_reg, skid_data_next;
    rsp_item_t result;

    logic in_fire, out_fire;

    // Datapath terms
    logic [MS_W-1:0]     dt;
    logic [POS_W-1:0]    target_mm;
    logic [STEP_W-1:0]   car_step;
    logic [STEP_W-1:0]   door_step;
    logic [POS_W:0]      pos_up;
    logic [POS_W:0]      target_up;
    logic                arrive;
    logic [STEP_W:0]     door_sum;
    logic [TIME_W-1:0]   open_age;
    logic                hold_done;
    logic [FLOOR_W-1:0]  head_floor;
    logic                add_ok;

    assign in_fire  = req.valid && req.ready;
    assign out_fire = out_valid_reg && rsp.ready;
    assign req.ready = !skid_valid_reg;

    assign dt        = (req.elapsed_ms < tick_cap_reg) ? req.elapsed_ms : tick_cap_reg;
    assign target_mm = POS_W'(heading_reg) * POS_W'(floor_height_reg);
    assign car_step  = STEP_W'(car_speed_reg) * STEP_W'(dt);
    assign door_step = STEP_W'(door_speed_reg) * STEP_W'(dt);
    assign pos_up    = (POS_W+1)'(car_pos_reg) + (POS_W+1)'(car_step);
    assign target_up = (POS_W+1)'(target_mm) + (POS_W+1)'(car_step);
    assign arrive    = (target_mm > car_pos_reg) ? (pos_up >= (POS_W+1)'(target_mm))
                                                 : ((POS_W+1)'(car_pos_reg) <= target_up);
    assign door_sum  = (STEP_W+1)'(door_travel_reg) + (STEP_W+1)'(door_step);
    assign open_age  = req.time_now_ms - open_start_reg;
    assign hold_done = open_age >= TIME_W'(door_hold_reg);
    assign head_floor = pending_mem[fifo_head_reg];
    assign add_ok    = (QCNT_W'(req.floor) < QCNT_W'(NUM_FLOORS))
                    && !((req.floor == arrived_reg) && !door_flag_reg)
                    && !queued_reg[req.floor]
                    && (fifo_count_reg < QCNT_W'(NUM_FLOORS));

    always_comb
    begin
        phase_next       = phase_reg;
        car_pos_next     = car_pos_reg;
        arrived_next     = arrived_reg;
        heading_next     = heading_reg;
        door_travel_next = door_travel_reg;
        door_flag_next   = door_flag_reg;
        open_start_next  = open_start_reg;
        hold_ext_next    = hold_ext_reg;
        frozen_next      = frozen_reg;
        fifo_head_next   = fifo_head_reg;
        fifo_count_next  = fifo_count_reg;
        queued_next      = queued_reg;
        lit_next         = lit_reg;
        pend_we          = 1'b0;
        pend_waddr       = fifo_head_reg + fifo_count_reg[FLOOR_W-1:0];

        case (req.mode)
            MODE_TICK:
            begin
                if (!frozen_reg)
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if ((fifo_count_reg != '0) && !door_flag_reg)
                            begin
                                heading_next    = head_floor;
                                queued_next[head_floor] = 1'b0;
                                fifo_head_next  = fifo_head_reg + 1'b1;
                                fifo_count_next = fifo_count_reg - 1'b1;
                                phase_next      = PH_MOVING;
                            end
                        end
                        PH_MOVING:
                        begin
                            if (arrive)
                            begin
                                car_pos_next     = target_mm;
                                arrived_next     = heading_reg;
                                lit_next[heading_reg] = 1'b0;
                                phase_next       = PH_OPEN;
                                door_flag_next   = 1'b1;
                                open_start_next  = req.time_now_ms;
                                hold_ext_next    = 1'b0;
                            end
                            else if (target_mm > car_pos_reg)
                            begin
                                car_pos_next = pos_up[POS_W-1:0];
                            end
                            else
                            begin
                                car_pos_next = car_pos_reg - POS_W'(car_step);
                            end
                        end
                        PH_OPEN:
                        begin
                            door_travel_next = (door_sum > (STEP_W+1)'(door_full_reg))
                                             ? door_full_reg : door_sum[DOOR_W-1:0];
                            if (hold_done)
                            begin
                                phase_next = PH_CLOSING;
                            end
                        end
                        default:
                        begin
                            // Closing: shut when travel reaches zero, then serve the queue or go idle
                            if (door_step >= STEP_W'(door_travel_reg))
                            begin
                                door_travel_next = '0;
                                door_flag_next   = 1'b0;
                                if (fifo_count_reg != '0)
                                begin
                                    heading_next    = head_floor;
                                    queued_next[head_floor] = 1'b0;
                                    fifo_head_next  = fifo_head_reg + 1'b1;
                                    fifo_count_next = fifo_count_reg - 1'b1;
                                    phase_next      = PH_MOVING;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                            else
                            begin
                                door_travel_next = door_travel_reg - door_step[DOOR_W-1:0];
                            end
                        end
                    endcase
                end
            end
            MODE_ADD:
            begin
                if (add_ok)
                begin
                    pend_we         = 1'b1;
                    fifo_count_next = fifo_count_reg + 1'b1;
                    queued_next[req.floor] = 1'b1;
                    lit_next[req.floor]    = 1'b1;
                    frozen_next     = 1'b0;
                end
            end
            MODE_STOP:
            begin
                fifo_count_next  = '0;
                queued_next      = '0;
                frozen_next      = 1'b1;
                phase_next       = PH_IDLE;
                door_flag_next   = 1'b0;
                door_travel_next = '0;
                hold_ext_next    = 1'b0;
                lit_next         = '0;
            end
            MODE_OPEN:
            begin
                if (phase_reg == PH_OPEN && door_flag_reg)
                begin
                    // Extend the hold only once per opening
                    if (!hold_ext_reg)
                    begin
                        open_start_next = req.time_now_ms;
                        hold_ext_next   = 1'b1;
                    end
                end
                else if (phase_reg != PH_MOVING)
                begin
                    phase_next      = PH_OPEN;
                    door_flag_next  = 1'b1;
                    open_start_next = req.time_now_ms;
                    hold_ext_next   = 1'b0;
                end
            end
            MODE_CLOSE:
            begin
                if (phase_reg == PH_OPEN)
                begin
                    phase_next = PH_CLOSING;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (phase_next)
            PH_IDLE:    result.phase = PCODE_IDLE;
            PH_MOVING:  result.phase = PCODE_MOVING;
            PH_OPEN:    result.phase = PCODE_OPEN;
            default:    result.phase = PCODE_CLOSING;
        endcase
        result.current_floor     = arrived_next;
        result.destination_floor = heading_next;
        result.car_position_mm   = car_pos_next;
        result.door_offset       = door_travel_next;
        result.doors_open        = door_flag_next;
        result.buttons_lit       = lit_next;
        result.stop_active       = frozen_next;
    end

    // Status buffer: output register backed by one skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = result;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_height_reg <= RST_FLOOR_HEIGHT;
            car_speed_reg    <= RST_CAR_SPEED;
            door_speed_reg   <= RST_DOOR_SPEED;
            door_full_reg    <= RST_DOOR_FULL;
            door_hold_reg    <= RST_DOOR_HOLD;
            tick_cap_reg     <= RST_TICK_CAP;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_FLOOR_HEIGHT: floor_height_reg <= cfg_data[12:0];
                CFG_CAR_SPEED:    car_speed_reg    <= cfg_data[3:0];
                CFG_DOOR_SPEED:   door_speed_reg   <= cfg_data[3:0];
                CFG_DOOR_FULL:    door_full_reg    <= cfg_data[DOOR_W-1:0];
                CFG_DOOR_HOLD:    door_hold_reg    <= cfg_data;
                CFG_TICK_CAP:     tick_cap_reg     <= cfg_data[MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            car_pos_reg     <= '0;
            arrived_reg     <= '0;
            heading_reg     <= '0;
            door_travel_reg <= '0;
            door_flag_reg   <= 1'b0;
            open_start_reg  <= '0;
            hold_ext_reg    <= 1'b0;
            frozen_reg      <= 1'b0;
            fifo_head_reg   <= '0;
            fifo_count_reg  <= '0;
            queued_reg      <= '0;
            lit_reg         <= '0;
        end
        else if (in_fire)
        begin
            phase_reg       <= phase_next;
            car_pos_reg     <= car_pos_next;
            arrived_reg     <= arrived_next;
            heading_reg     <= heading_next;
            door_travel_reg <= door_travel_next;
            door_flag_reg   <= door_flag_next;
            open_start_reg  <= open_start_next;
            hold_ext_reg    <= hold_ext_next;
            frozen_reg      <= frozen_next;
            fifo_head_reg   <= fifo_head_next;
            fifo_count_reg  <= fifo_count_next;
            queued_reg      <= queued_next;
            lit_reg         <= lit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && pend_we)
        begin
            pending_mem[pend_waddr] <= req.floor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.phase             = out_data_reg.phase;
    assign rsp.current_floor     = out_data_reg.current_floor;
    assign rsp.destination_floor = out_data_reg.destination_floor;
    assign rsp.car_position_mm   = out_data_reg.car_position_mm;
    assign rsp.door_offset       = out_data_reg.door_offset;
    assign rsp.doors_open        = out_data_reg.doors_open;
    assign rsp.buttons_lit       = out_data_reg.buttons_lit;
    assign rsp.stop_active       = out_data_reg.stop_active;

    // The skid register only fills behind a held output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register occupied with output register empty");

    // Queue holds no duplicates, so its membership map counts its entries
    a_queue_map: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(queued_reg) == 32'(fifo_count_reg))
        && (fifo_count_reg <= QCNT_W'(NUM_FLOORS)))
        else $error("queue membership map disagrees with queue count");

    // The car never travels with the doors unshut
    a_moving_shut: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MOVING) |-> !door_flag_reg)
        else $error("car moving with doors open");

    // Door phases always keep the doors flagged open
    a_door_phase_flag: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_OPEN) || (phase_reg == PH_CLOSING)) |-> door_flag_reg)
        else $error("door phase without door flag");

endmodule
